>>> rtl/pps_pkg.sv
// pps_pkg: shared types, widths and codes for the procedural pattern shader
// no dependencies; imported by every module of the block
package pps_pkg;

	localparam int unsigned MAG_W  = 32;
	localparam int unsigned SQ_W   = 2 * MAG_W;
	localparam int unsigned ROOT_W = MAG_W;
	localparam int unsigned COL_W  = 24;
	localparam int unsigned CH_W   = 8;

	localparam logic [1:0] MODE_PLAIN   = 2'd0;
	localparam logic [1:0] MODE_STRIPES = 2'd1;
	localparam logic [1:0] MODE_CHECKER = 2'd2;
	localparam logic [1:0] MODE_RINGS   = 2'd3;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_SIZE    = 2'd1;
	localparam logic [1:0] REG_COLOR_A = 2'd2;
	localparam logic [1:0] REG_COLOR_B = 2'd3;

	localparam logic [MAG_W-1:0] SIZE_RESET  = 32'h0001_0000;
	localparam logic [MAG_W-1:0] SIZE_MAX    = 32'hFFFF_FFFF;
	localparam logic [COL_W-1:0] COLOR_A_RST = 24'h000000;
	localparam logic [COL_W-1:0] COLOR_B_RST = 24'hFFFFFF;

	typedef struct packed {
		logic sx;
		logic sz;
	} pps_sgn_t;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] az;
		pps_sgn_t         sgn;
	} pps_tag_t;

endpackage

>>> rtl/pps_front.sv
// pps_front: magnitudes and signs, squares, sum of squares (three stages)
// depends on pps_pkg
module pps_front import pps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MAG_W-1:0]  x_pos,
	input  logic [MAG_W-1:0]  z_pos,
	output logic              out_valid,
	output logic [SQ_W-1:0]   out_sum,
	output pps_tag_t          out_tag
);

	logic             valid_s1, valid_s2, valid_s3;
	pps_tag_t         tag_s1, tag_s2, tag_s3;
	logic [SQ_W-1:0]  sqx_s2, sqz_s2, sum_s3;
	logic [MAG_W-1:0] ax, az;

	// two's complement negate keeps the most negative value as 2^31
	assign ax = x_pos[MAG_W-1] ? (~x_pos + 1'b1) : x_pos;
	assign az = z_pos[MAG_W-1] ? (~z_pos + 1'b1) : z_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.ax     <= ax;
		tag_s1.az     <= az;
		tag_s1.sgn.sx <= !x_pos[MAG_W-1] && (x_pos != '0);
		tag_s1.sgn.sz <= !z_pos[MAG_W-1] && (z_pos != '0);
		tag_s2        <= tag_s1;
		sqx_s2        <= SQ_W'(tag_s1.ax) * SQ_W'(tag_s1.ax);
		sqz_s2        <= SQ_W'(tag_s1.az) * SQ_W'(tag_s1.az);
		tag_s3        <= tag_s2;
		sum_s3        <= sqx_s2 + sqz_s2;
	end

	assign out_valid = valid_s3;
	assign out_sum   = sum_s3;
	assign out_tag   = tag_s3;

endmodule

>>> rtl/pps_sqrt_pipe.sv
// pps_sqrt_pipe: floor square root of a 64-bit value, one root bit per stage
// depends on pps_pkg
module pps_sqrt_pipe import pps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   in_sum,
	input  pps_tag_t          in_tag,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output pps_tag_t          out_tag
);

	localparam int unsigned REM_W = ROOT_W + 2;

	logic              vld_s [ROOT_W];
	logic [SQ_W-1:0]   val_s [ROOT_W];
	logic [REM_W-1:0]  rem_s [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	pps_tag_t          tag_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int unsigned BI = ROOT_W - 1 - k;
		logic              vld_c;
		logic [SQ_W-1:0]   val_c;
		logic [REM_W-1:0]  rem_c, rem_n, trial;
		logic [ROOT_W-1:0] root_c;
		pps_tag_t          tag_c;

		if (k == 0) begin : g_first
			assign vld_c  = in_valid;
			assign val_c  = in_sum;
			assign rem_c  = '0;
			assign root_c = '0;
			assign tag_c  = in_tag;
		end else begin : g_next
			assign vld_c  = vld_s[k-1];
			assign val_c  = val_s[k-1];
			assign rem_c  = rem_s[k-1];
			assign root_c = root_s[k-1];
			assign tag_c  = tag_s[k-1];
		end

		// bring down the next two bits, try root*4+1
		assign rem_n = {rem_c[REM_W-3:0], val_c[2*BI+1 -: 2]};
		assign trial = {root_c, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			val_s[k] <= val_c;
			tag_s[k] <= tag_c;
			if (rem_n >= trial) begin
				rem_s[k]  <= rem_n - trial;
				root_s[k] <= {root_c[ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[k]  <= rem_n;
				root_s[k] <= {root_c[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];
	assign out_tag   = tag_s[ROOT_W-1];

endmodule

>>> rtl/pps_div_pipe.sv
// pps_div_pipe: two-lane restoring divider, one quotient bit per stage
// only the quotient parity leaves the unit; depends on pps_pkg
module pps_div_pipe import pps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [MAG_W-1:0] in_a0,
	input  logic [MAG_W-1:0] in_a1,
	input  logic [MAG_W-1:0] divisor,
	input  pps_sgn_t         in_sgn,
	output logic             out_valid,
	output logic             out_m0,
	output logic             out_m1,
	output pps_sgn_t         out_sgn
);

	localparam int unsigned REM_W = MAG_W + 1;

	logic             vld_s [MAG_W];
	logic [MAG_W-1:0] a0_s [MAG_W];
	logic [MAG_W-1:0] a1_s [MAG_W];
	logic [REM_W-1:0] r0_s [MAG_W];
	logic [REM_W-1:0] r1_s [MAG_W];
	logic             q0_s [MAG_W];
	logic             q1_s [MAG_W];
	pps_sgn_t         sgn_s [MAG_W];

	for (genvar k = 0; k < MAG_W; k++) begin : g_stage
		localparam int unsigned BI = MAG_W - 1 - k;
		logic             vld_c;
		logic [MAG_W-1:0] a0_c, a1_c;
		logic [REM_W-1:0] r0_c, r1_c, t0, t1, dv;
		pps_sgn_t         sgn_c;

		if (k == 0) begin : g_first
			assign vld_c = in_valid;
			assign a0_c  = in_a0;
			assign a1_c  = in_a1;
			assign r0_c  = '0;
			assign r1_c  = '0;
			assign sgn_c = in_sgn;
		end else begin : g_next
			assign vld_c = vld_s[k-1];
			assign a0_c  = a0_s[k-1];
			assign a1_c  = a1_s[k-1];
			assign r0_c  = r0_s[k-1];
			assign r1_c  = r1_s[k-1];
			assign sgn_c = sgn_s[k-1];
		end

		assign t0 = {r0_c[MAG_W-1:0], a0_c[BI]};
		assign t1 = {r1_c[MAG_W-1:0], a1_c[BI]};
		assign dv = {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			a0_s[k]  <= a0_c;
			a1_s[k]  <= a1_c;
			sgn_s[k] <= sgn_c;
			q0_s[k]  <= (t0 >= dv);
			q1_s[k]  <= (t1 >= dv);
			r0_s[k]  <= (t0 >= dv) ? (t0 - dv) : t0;
			r1_s[k]  <= (t1 >= dv) ? (t1 - dv) : t1;
		end
	end

	assign out_valid = vld_s[MAG_W-1];
	assign out_m0    = q0_s[MAG_W-1];
	assign out_m1    = q1_s[MAG_W-1];
	assign out_sgn   = sgn_s[MAG_W-1];

endmodule

>>> rtl/procedural_pattern_shader.sv
// procedural_pattern_shader: top level, config registers, pattern select, output register
// depends on pps_pkg, pps_front, pps_sqrt_pipe, pps_div_pipe
//
//  channel   signals                       transfer
//  input     start, busy, x_pos, z_pos     edge with start high, busy low
//  config    cfg_we, cfg_addr, cfg_wdata   edge with cfg_we high
//  result    done, red, green, blue        edge ending the cycle done is high
//
// one point enters every cycle; busy is always low
// path: 3 front stages, 32 root stages, 32 divider stages, output register
// the root and divider pipelines retire one bit per stage, which sets the depth
// reset clears all valid bits and loads the register defaults
// nothing stalls: the receiver takes every result as it appears
module procedural_pattern_shader import pps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [MAG_W-1:0] x_pos,
	input  logic [MAG_W-1:0] z_pos,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [MAG_W-1:0] cfg_wdata,
	output logic             done,
	output logic [CH_W-1:0]  red,
	output logic [CH_W-1:0]  green,
	output logic [CH_W-1:0]  blue
);

	logic [1:0]        mode_q;
	logic [MAG_W-1:0]  size_q, eff_size;
	logic [COL_W-1:0]  color_a_q, color_b_q, col;
	logic              fr_valid, rt_valid, dv_valid;
	logic [SQ_W-1:0]   fr_sum;
	pps_tag_t          fr_tag, rt_tag;
	logic [ROOT_W-1:0] rt_root;
	logic [MAG_W-1:0]  lane0;
	logic              m0, m1, idx;
	pps_sgn_t          dv_sgn;
	logic              done_q;
	logic [COL_W-1:0]  rgb_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			size_q    <= SIZE_RESET;
			color_a_q <= COLOR_A_RST;
			color_b_q <= COLOR_B_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODE:    mode_q    <= cfg_wdata[1:0];
				REG_SIZE:    size_q    <= cfg_wdata;
				REG_COLOR_A: color_a_q <= cfg_wdata[COL_W-1:0];
				REG_COLOR_B: color_b_q <= cfg_wdata[COL_W-1:0];
				default:     mode_q    <= mode_q;
			endcase
		end
	end

	// zero size counts as the largest
	assign eff_size = (size_q == '0) ? SIZE_MAX : size_q;

	pps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.x_pos     (x_pos),
		.z_pos     (z_pos),
		.out_valid (fr_valid),
		.out_sum   (fr_sum),
		.out_tag   (fr_tag)
	);

	pps_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_sum    (fr_sum),
		.in_tag    (fr_tag),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_tag   (rt_tag)
	);

	assign lane0 = (mode_q == MODE_RINGS) ? rt_root : rt_tag.ax;

	pps_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_a0     (lane0),
		.in_a1     (rt_tag.az),
		.divisor   (eff_size),
		.in_sgn    (rt_tag.sgn),
		.out_valid (dv_valid),
		.out_m0    (m0),
		.out_m1    (m1),
		.out_sgn   (dv_sgn)
	);

	always_comb begin
		unique case (mode_q)
			MODE_PLAIN:   idx = 1'b0;
			MODE_STRIPES: idx = dv_sgn.sx ? m0 : !m0;
			MODE_CHECKER: idx = !(m0 ^ m1 ^ dv_sgn.sx ^ dv_sgn.sz);
			MODE_RINGS:   idx = m0;
			default:      idx = 1'b0;
		endcase
	end

	assign col = idx ? color_b_q : color_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		rgb_q <= col;
	end

	assign done  = done_q;
	assign red   = rgb_q[23:16];
	assign green = rgb_q[15:8];
	assign blue  = rgb_q[7:0];

endmodule

>>> rtl/pps_checker.sv
// pps_checker: port-level checks for procedural_pattern_shader, bound to the top level
// depends on pps_pkg; tracks the mode and color registers from the write port
module pps_checker import pps_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             cfg_we,
	input logic [1:0]       cfg_addr,
	input logic [MAG_W-1:0] cfg_wdata,
	input logic             done,
	input logic [CH_W-1:0]  red,
	input logic [CH_W-1:0]  green,
	input logic [CH_W-1:0]  blue
);

	// accept edge to the edge that ends the result cycle
	localparam int unsigned LATENCY = 68;

	logic [1:0]       mode_q;
	logic [COL_W-1:0] color_a_q, color_b_q, rgb;

	assign rgb = {red, green, blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			color_a_q <= COLOR_A_RST;
			color_b_q <= COLOR_B_RST;
		end else if (cfg_we) begin
			if (cfg_addr == REG_MODE) mode_q <= cfg_wdata[1:0];
			if (cfg_addr == REG_COLOR_A) color_a_q <= cfg_wdata[COL_W-1:0];
			if (cfg_addr == REG_COLOR_B) color_b_q <= cfg_wdata[COL_W-1:0];
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_color_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rgb == color_a_q || rgb == color_b_q))
		else $error("result is neither configured color");

	a_plain_a: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_q == MODE_PLAIN) |-> (rgb == color_a_q))
		else $error("plain mode did not give color a");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("result right after reset");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input transfer");

endmodule

bind procedural_pattern_shader pps_checker u_pps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_we    (cfg_we),
	.cfg_addr  (cfg_addr),
	.cfg_wdata (cfg_wdata),
	.done      (done),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
